@@ rtl/core/fastq_record_splitter_unit_defines.svh @@
// ------------------------------------------------------------------------
// fastq record splitter assertion macros
// shared concurrent assertion forms, clocked on clk_i, off during reset
// ------------------------------------------------------------------------
`ifndef FASTQ_RECORD_SPLITTER_UNIT_DEFINES_SVH
`define FASTQ_RECORD_SPLITTER_UNIT_DEFINES_SVH

// property that must hold at every edge out of reset
`define FQS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must be followed by another at the next edge
`define FQS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/fqs_pkg.sv @@
// ------------------------------------------------------------------------
// fqs_pkg
// types and constants shared by the fastq record splitter modules
// ------------------------------------------------------------------------
`default_nettype none

package fqs_pkg;

  // character codes
  localparam logic [7:0] ChAt = 8'h40;
  localparam logic [7:0] ChLf = 8'h0a;
  localparam logic [7:0] ChCr = 8'h0d;

  // field ids
  localparam logic [1:0] FidName   = 2'd0;
  localparam logic [1:0] FidSeq    = 2'd1;
  localparam logic [1:0] FidStrand = 2'd2;
  localparam logic [1:0] FidQual   = 2'd3;

  // flush count width, covers held cr bounds up to 63
  localparam int unsigned CrCntW = 6;

  // depth of the command queue between front and back
  localparam int unsigned CmdFifoDepth = 2;

  typedef enum logic [2:0] {
    PhSkip   = 3'd0,
    PhName   = 3'd1,
    PhSeq    = 3'd2,
    PhStrand = 3'd3,
    PhQstart = 3'd4,
    PhQual   = 3'd5,
    PhDead   = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    StNone  = 3'd0,
    StOk    = 3'd1,
    StTrunc = 3'd2,
    StNoHdr = 3'd3,
    StCrOvf = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       chunk_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [1:0] field_id;
    logic       field_end;
    logic [2:0] status;
    logic       last_of_run;
  } out_item_t;

  // work for one input item: held crs, then main result, then chunk-end tail
  typedef struct packed {
    logic [CrCntW-1:0] flush_cnt;
    logic              has_main;
    logic [7:0]        main_byte;
    logic              main_valid;
    logic [1:0]        fid;
    logic              main_fend;
    status_e           main_status;
    logic              has_tail;
    logic [1:0]        tail_fid;
    logic              tail_fend;
    status_e           tail_status;
  } cmd_t;

  function automatic logic [1:0] field_of(phase_e ph);
    logic [1:0] f;
    case (ph)
      PhName:   f = FidName;
      PhSeq:    f = FidSeq;
      PhStrand: f = FidStrand;
      PhQstart: f = FidQual;
      PhQual:   f = FidQual;
      default:  f = FidName;
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/fqs_front.sv @@
// ------------------------------------------------------------------------
// fqs_front
// parses the byte stream, keeps phase and held cr count, issues commands
// ------------------------------------------------------------------------
`default_nettype none

module fqs_front #(
  parameter int unsigned MAX_PENDING_CR = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic             full_i,
  input  wire fqs_pkg::in_item_t item_i,
  output logic                  cmd_push_o,
  output fqs_pkg::cmd_t         cmd_o
);

  localparam int unsigned HeldW = $clog2(MAX_PENDING_CR + 1);

  fqs_pkg::phase_e  phase_q, phase_d;
  logic [HeldW-1:0] held_q, held_d;
  logic             accept;
  logic [7:0]       b;
  logic [1:0]       fid;
  fqs_pkg::cmd_t    cmd;

  assign accept = push_i && !full_i;
  assign b      = item_i.data_byte;
  assign fid    = fqs_pkg::field_of(phase_q);

  always_comb begin
    phase_d         = phase_q;
    held_d          = held_q;
    cmd             = '0;
    cmd.fid         = fid;
    cmd.main_status = fqs_pkg::StNone;
    cmd.tail_status = fqs_pkg::StNone;
    case (phase_q)
      fqs_pkg::PhSkip: begin
        if (b == fqs_pkg::ChLf || b == fqs_pkg::ChCr) begin
          phase_d = fqs_pkg::PhSkip;
        end else if (b == fqs_pkg::ChAt) begin
          cmd.has_main   = 1'b1;
          cmd.main_byte  = b;
          cmd.main_valid = 1'b1;
          phase_d        = fqs_pkg::PhName;
        end else begin
          cmd.has_main    = 1'b1;
          cmd.main_status = fqs_pkg::StNoHdr;
          phase_d         = fqs_pkg::PhDead;
        end
      end
      fqs_pkg::PhName, fqs_pkg::PhSeq, fqs_pkg::PhStrand, fqs_pkg::PhQual: begin
        if (b == fqs_pkg::ChLf) begin
          held_d        = '0;
          cmd.has_main  = 1'b1;
          cmd.main_fend = 1'b1;
          if (phase_q == fqs_pkg::PhQual) begin
            cmd.main_status = fqs_pkg::StOk;
          end
          case (phase_q)
            fqs_pkg::PhName:   phase_d = fqs_pkg::PhSeq;
            fqs_pkg::PhSeq:    phase_d = fqs_pkg::PhStrand;
            fqs_pkg::PhStrand: phase_d = fqs_pkg::PhQstart;
            default:           phase_d = fqs_pkg::PhSkip;
          endcase
        end else if (b == fqs_pkg::ChCr) begin
          if (held_q < HeldW'(MAX_PENDING_CR)) begin
            held_d = HeldW'(held_q + 1'b1);
          end else begin
            cmd.has_main    = 1'b1;
            cmd.main_status = fqs_pkg::StCrOvf;
          end
        end else begin
          // held crs go out ahead of this byte
          cmd.flush_cnt  = fqs_pkg::CrCntW'(held_q);
          held_d         = '0;
          cmd.has_main   = 1'b1;
          cmd.main_byte  = b;
          cmd.main_valid = 1'b1;
        end
      end
      fqs_pkg::PhQstart: begin
        if (b == fqs_pkg::ChLf) begin
          cmd.has_main    = 1'b1;
          cmd.main_fend   = 1'b1;
          cmd.main_status = fqs_pkg::StOk;
          phase_d         = fqs_pkg::PhSkip;
        end else if (b == fqs_pkg::ChCr) begin
          held_d  = HeldW'(1);
          phase_d = fqs_pkg::PhQual;
        end else begin
          cmd.has_main   = 1'b1;
          cmd.main_byte  = b;
          cmd.main_valid = 1'b1;
          phase_d        = fqs_pkg::PhQual;
        end
      end
      default: begin
        phase_d = phase_q;
      end
    endcase

    if (item_i.chunk_last) begin
      case (phase_d)
        fqs_pkg::PhName, fqs_pkg::PhSeq, fqs_pkg::PhStrand, fqs_pkg::PhQstart: begin
          cmd.has_tail    = 1'b1;
          cmd.tail_fid    = fqs_pkg::field_of(phase_d);
          cmd.tail_status = fqs_pkg::StTrunc;
        end
        fqs_pkg::PhQual: begin
          cmd.has_tail    = 1'b1;
          cmd.tail_fid    = fqs_pkg::FidQual;
          cmd.tail_fend   = 1'b1;
          cmd.tail_status = fqs_pkg::StOk;
        end
        default: begin
          cmd.has_tail = 1'b0;
        end
      endcase
      phase_d = fqs_pkg::PhSkip;
      held_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= fqs_pkg::PhSkip;
      held_q  <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

  assign cmd_push_o = accept && (cmd.has_main || cmd.has_tail);
  assign cmd_o      = cmd;

endmodule

`default_nettype wire

@@ rtl/core/fqs_cmd_fifo.sv @@
// ------------------------------------------------------------------------
// fqs_cmd_fifo
// short command queue that decouples the parser from the result sequencer
// ------------------------------------------------------------------------
`default_nettype none

`include "fastq_record_splitter_unit_defines.svh"

module fqs_cmd_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          wr_i,
  input  wire fqs_pkg::cmd_t wr_data_i,
  output logic               full_o,
  input  wire logic          rd_i,
  output logic               rd_valid_o,
  output fqs_pkg::cmd_t      rd_data_o
);

  localparam int unsigned Depth = fqs_pkg::CmdFifoDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  fqs_pkg::cmd_t   mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_wr, do_rd;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign do_wr      = wr_i && !full_o;
  assign do_rd      = rd_i && rd_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(wr_ptr_q + 1'b1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(rd_ptr_q + 1'b1);
    end
    if (do_wr && !do_rd) begin
      cnt_d = CntW'(cnt_q + 1'b1);
    end else if (do_rd && !do_wr) begin
      cnt_d = CntW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  `FQS_ASSERT(a_cnt_bound, cnt_q <= CntW'(Depth), "command queue count past depth")
  `FQS_ASSERT(a_no_read_empty, !(rd_i && !rd_valid_o), "command queue read while empty")

endmodule

`default_nettype wire

@@ rtl/core/fqs_back.sv @@
// ------------------------------------------------------------------------
// fqs_back
// plays out one command as a run of result items, one per cycle while pop is high
// ------------------------------------------------------------------------
`default_nettype none

`include "fastq_record_splitter_unit_defines.svh"

module fqs_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cmd_valid_i,
  input  wire fqs_pkg::cmd_t  cmd_i,
  output logic                cmd_pop_o,
  output logic                empty,
  input  wire logic           pop,
  output fqs_pkg::out_item_t  out_item_o
);

  logic          busy_q, busy_d;
  fqs_pkg::cmd_t cmd_q, cmd_d;
  logic          flushing;
  logic          fire, done, load;

  assign flushing = (cmd_q.flush_cnt != '0);

  always_comb begin
    out_item_o = '0;
    if (flushing) begin
      out_item_o.out_byte   = fqs_pkg::ChCr;
      out_item_o.byte_valid = 1'b1;
      out_item_o.field_id   = cmd_q.fid;
      out_item_o.status     = fqs_pkg::StNone;
    end else if (cmd_q.has_main) begin
      out_item_o.out_byte    = cmd_q.main_byte;
      out_item_o.byte_valid  = cmd_q.main_valid;
      out_item_o.field_id    = cmd_q.fid;
      out_item_o.field_end   = cmd_q.main_fend;
      out_item_o.status      = cmd_q.main_status;
      out_item_o.last_of_run = !cmd_q.has_tail;
    end else begin
      out_item_o.field_id    = cmd_q.tail_fid;
      out_item_o.field_end   = cmd_q.tail_fend;
      out_item_o.status      = cmd_q.tail_status;
      out_item_o.last_of_run = 1'b1;
    end
  end

  assign empty     = !busy_q;
  assign fire      = busy_q && pop;
  assign done      = fire && out_item_o.last_of_run;
  assign load      = (!busy_q || done) && cmd_valid_i;
  assign cmd_pop_o = load;

  always_comb begin
    cmd_d  = cmd_q;
    busy_d = busy_q;
    if (load) begin
      cmd_d  = cmd_i;
      busy_d = 1'b1;
    end else if (done) begin
      busy_d = 1'b0;
    end else if (fire) begin
      if (flushing) begin
        cmd_d.flush_cnt = fqs_pkg::CrCntW'(cmd_q.flush_cnt - 1'b1);
      end else begin
        cmd_d.has_main = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  `FQS_ASSERT(a_flush_has_main, !(busy_q && flushing) || cmd_q.has_main, "cr flush without data")
  `FQS_ASSERT(a_busy_has_work, !busy_q || cmd_q.has_main || cmd_q.has_tail, "command with no results")
  `FQS_ASSERT_NEXT(a_done_idle, done && !cmd_valid_i, empty, "sequencer busy after last result")

endmodule

`default_nettype wire

@@ rtl/core/fastq_record_splitter_unit.sv @@
// ------------------------------------------------------------------------
// fastq_record_splitter_unit
// splits a chunk of fastq text into tagged name, sequence, strand, quality
// ------------------------------------------------------------------------
// usage
//   input channel: drive in_item_i and raise push; the item is taken on an
//   edge where full is low. chunk_last marks the final byte of a chunk.
//   output channel: while empty is low, out_item_o holds the oldest result;
//   raise pop to take it. last_of_run flags the final result of one byte.
// result path
//   the parser writes a byte's command into the command queue at its push
//   edge; the sequencer then loads it into its command register once free,
//   and the first result of the byte shows on the ports from that register
// throughput
//   the parser takes one byte per cycle while full is low; the result
//   sequencer gives one result per cycle while pop is high, so a byte
//   that flushes n held crs plus a chunk-end marker gives up to n + 2
//   results; bytes that give no result push no command
// reset
//   parser goes back to skipping between records, held cr count clears,
//   command queue and sequencer come up empty
// stalls
//   when pop stays low the two-entry command queue fills and full rises;
//   nothing is dropped
// ------------------------------------------------------------------------
`default_nettype none

module fastq_record_splitter_unit #(
  parameter int unsigned MAX_PENDING_CR = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // input channel
  input  wire logic               push,
  output logic                    full,
  input  wire fqs_pkg::in_item_t  in_item_i,
  // result channel
  output logic                    empty,
  input  wire logic               pop,
  output fqs_pkg::out_item_t      out_item_o
);

  // parser to queue
  logic          cmd_push;
  fqs_pkg::cmd_t cmd_wr;
  // queue to sequencer
  logic          cmd_valid;
  logic          cmd_pop;
  fqs_pkg::cmd_t cmd_rd;

  // front: phase tracking, cr holding, one command per result-bearing byte
  fqs_front #(
    .MAX_PENDING_CR(MAX_PENDING_CR)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_i     (full),
    .item_i     (in_item_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_wr)
  );

  // short queue so parser and sequencer stall on their own
  fqs_cmd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (cmd_push),
    .wr_data_i  (cmd_wr),
    .full_o     (full),
    .rd_i       (cmd_pop),
    .rd_valid_o (cmd_valid),
    .rd_data_o  (cmd_rd)
  );

  // back: crs, then the byte or marker, then any chunk-end marker
  fqs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_rd),
    .cmd_pop_o   (cmd_pop),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire
